// File: sv/alrob_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alrob_pkg
// Shared types and constants of the active list.
// ----------------------------------------------------------------------------
package alrob_pkg;

    localparam int DEF_ENTRIES      = 32;
    localparam int DEF_RETIRE_MAX   = 4;
    localparam int DEF_CHECKPOINTS  = 4;
    localparam int DEF_LOGICAL_REGS = 32;

    localparam int CMD_W  = 4;
    localparam int IDX_W  = 5;
    localparam int SLOT_W = 2;
    localparam int PC_W   = 32;
    localparam int DST_W  = 5;
    localparam int TAG_W  = 6;
    localparam int ST_W   = 2;
    localparam int OCC_W  = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACCEPT   = 4'd0,
        CMD_COMPLETE = 4'd1,
        CMD_EXCEPT   = 4'd2,
        CMD_RETIRE   = 4'd3,
        CMD_CKPT     = 4'd4,
        CMD_REWIND   = 4'd5,
        CMD_UNMAP    = 4'd6,
        CMD_READ_PC  = 4'd7,
        CMD_HEAD_Q   = 4'd8
    } cmd_t;

    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [IDX_W-1:0]  entry_index;
        logic [SLOT_W-1:0] slot;
        logic [PC_W-1:0]   pc_tag;
        logic [DST_W-1:0]  dest_reg;
        logic [TAG_W-1:0]  old_tag;
    } item_t;

endpackage
`default_nettype wire

// File: sv/alrob_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alrob_front
// Command front end: take items into a two-entry queue toward the back end.
// ----------------------------------------------------------------------------
module alrob_front
(
    input  wire                logic clk,
    input  wire                logic rst_n,
    input  wire                logic push,
    input  alrob_pkg::item_t   push_item,
    output logic               full,
    output logic               q_valid,
    output alrob_pkg::item_t   q_item,
    input  wire                logic pop
);
    import alrob_pkg::*;

    item_t      mem_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, rd_next, wr_reg, wr_next;

    assign full    = (cnt_reg == 2'd2);
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = mem_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        rd_next  = rd_reg ^ pop;
        wr_next  = wr_reg ^ push;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_item;
        end
    end
endmodule
`default_nettype wire

// File: sv/alrob_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// alrob_back
// One command per cycle, held while a retire gives one result per cycle.
// ----------------------------------------------------------------------------
module alrob_back
#(
    parameter int ENTRIES      = alrob_pkg::DEF_ENTRIES,
    parameter int RETIRE_MAX   = alrob_pkg::DEF_RETIRE_MAX,
    parameter int CHECKPOINTS  = alrob_pkg::DEF_CHECKPOINTS,
    parameter int LOGICAL_REGS = alrob_pkg::DEF_LOGICAL_REGS
)
(
    input  wire              logic clk,
    input  wire              logic rst_n,
    input  wire              logic q_valid,
    input  alrob_pkg::item_t q_item,
    output logic             pop,
    output logic             strobe,
    output logic [alrob_pkg::ST_W-1:0]  status,
    output logic [alrob_pkg::TAG_W-1:0] new_tag,
    output logic [alrob_pkg::IDX_W-1:0] entry_tag,
    output logic [alrob_pkg::TAG_W-1:0] freed_tag,
    output logic [alrob_pkg::DST_W-1:0] dest_reg_out,
    output logic [alrob_pkg::PC_W-1:0]  pc_out,
    output logic             head_exception,
    output logic [alrob_pkg::OCC_W-1:0] occupancy,
    output logic             last
);
    import alrob_pkg::*;

    localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PW  = AW + 1;
    localparam int CW  = (CHECKPOINTS > 1) ? $clog2(CHECKPOINTS) : 1;
    localparam int RW  = $clog2(RETIRE_MAX + 1);

    logic             done_reg  [ENTRIES];
    logic             fault_reg [ENTRIES];
    logic [PC_W-1:0]  pc_mem    [ENTRIES];
    logic [DST_W-1:0] dst_mem   [ENTRIES];
    logic [TAG_W-1:0] old_mem   [ENTRIES];
    logic [TAG_W-1:0] free_reg  [ENTRIES];
    logic             free_vld_reg [ENTRIES];
    logic [PW-1:0]    saved_reg [CHECKPOINTS];

    logic [PW-1:0]    tail_reg, tail_next, head_reg, head_next;
    logic [RW-1:0]    rcnt_reg, rcnt_next;

    logic [PW-1:0]    occ_now, occ_aft, head_fin;
    logic [AW-1:0]    t_idx, h_idx, tm_idx, h_aft, e_idx, r_idx;
    logic             retiring, is_ret, acc_ok, run_on;
    logic             hd_done, hd_fault;
    logic [RW-1:0]    run_n;
    logic             slot_ok;
    logic [CW-1:0]    slot_i;
    logic [TAG_W-1:0] free_rd;

    always_comb
    begin
        e_idx   = AW'(q_item.entry_index);
        t_idx   = tail_reg[AW-1:0];
        h_idx   = head_reg[AW-1:0];
        tm_idx  = AW'(tail_reg - PW'(1));
        occ_now = tail_reg - head_reg;
        slot_ok = ({{(32-SLOT_W){1'b0}}, q_item.slot} < CHECKPOINTS);
        slot_i  = CW'(q_item.slot);
        free_rd = free_vld_reg[t_idx] ? free_reg[t_idx]
                                      : TAG_W'(LOGICAL_REGS + 32'(t_idx));
        is_ret  = (q_item.command == CMD_RETIRE);
        acc_ok  = (q_item.command == CMD_ACCEPT) && (occ_now < PW'(ENTRIES));
    end

    // count the entries this retire item still frees
    always_comb
    begin
        run_n  = '0;
        run_on = is_ret;
        r_idx  = h_idx;
        for (int k = 0; k < RETIRE_MAX; k++)
        begin
            r_idx = AW'(head_reg + PW'(k));
            if (run_on && (k + int'(rcnt_reg) < RETIRE_MAX) && (k < int'(occ_now))
                && done_reg[r_idx] && !fault_reg[r_idx])
                run_n = run_n + RW'(1);
            else
                run_on = 1'b0;
        end
        head_fin = head_reg + PW'(run_n);
        retiring = (run_n != '0);
    end

    always_comb
    begin
        tail_next = tail_reg;
        head_next = head_reg;
        status    = ST_DONE;
        new_tag   = '0;
        entry_tag = '0;
        freed_tag = '0;
        dest_reg_out = '0;
        pc_out    = '0;
        if (q_valid)
        begin
            unique case (q_item.command)
                CMD_ACCEPT:
                begin
                    if (occ_now >= PW'(ENTRIES))
                        status = ST_FULL;
                    else
                    begin
                        new_tag   = free_rd;
                        entry_tag = IDX_W'(t_idx);
                        tail_next = tail_reg + PW'(1);
                    end
                end
                CMD_RETIRE:
                begin
                    if (retiring)
                    begin
                        freed_tag = old_mem[h_idx];
                        head_next = head_reg + PW'(1);
                    end
                    else if (rcnt_reg == '0)
                        status = ST_EMPTY;
                end
                CMD_REWIND:
                begin
                    if (slot_ok)
                        tail_next = saved_reg[slot_i];
                end
                CMD_UNMAP:
                begin
                    if (occ_now == '0)
                        status = ST_EMPTY;
                    else
                    begin
                        tail_next    = tail_reg - PW'(1);
                        freed_tag    = old_mem[tm_idx];
                        dest_reg_out = dst_mem[tm_idx];
                    end
                end
                CMD_READ_PC:
                    pc_out = pc_mem[e_idx];
                CMD_HEAD_Q:
                begin
                    if (occ_now != '0 && done_reg[h_idx] && fault_reg[h_idx])
                        pc_out = pc_mem[h_idx];
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        occ_aft  = tail_next - head_fin;
        h_aft    = head_fin[AW-1:0];
        hd_done  = done_reg[h_aft]
                   || (q_valid && q_item.command == CMD_COMPLETE && e_idx == h_aft);
        hd_fault = fault_reg[h_aft]
                   || (q_valid && q_item.command == CMD_EXCEPT && e_idx == h_aft);
        // retire item: a result on each freed entry, or one status result
        strobe = q_valid && !(is_ret && !retiring && rcnt_reg != '0);
        last   = strobe && !(retiring && run_n != RW'(1));
        pop    = q_valid && !(retiring && run_n != RW'(1));
        if (pop)
            rcnt_next = '0;
        else if (q_valid && is_ret)
            rcnt_next = rcnt_reg + RW'(1);
        else
            rcnt_next = rcnt_reg;
        head_exception = (occ_aft != '0) && !(q_valid && acc_ok && occ_now == '0)
                         && hd_done && hd_fault;
        occupancy = OCC_W'(occ_aft);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_reg <= '0;
            head_reg <= '0;
            rcnt_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
                free_vld_reg[i] <= 1'b0;
        end
        else
        begin
            tail_reg <= tail_next;
            head_reg <= head_next;
            rcnt_reg <= rcnt_next;
            if (q_valid && retiring)
                free_vld_reg[h_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_valid)
        begin
            if (retiring)
                free_reg[h_idx] <= old_mem[h_idx];
            if (q_item.command == CMD_ACCEPT && occ_now < PW'(ENTRIES))
            begin
                done_reg[t_idx]  <= 1'b0;
                fault_reg[t_idx] <= 1'b0;
                pc_mem[t_idx]    <= q_item.pc_tag;
                dst_mem[t_idx]   <= q_item.dest_reg;
                old_mem[t_idx]   <= q_item.old_tag;
            end
            if (q_item.command == CMD_COMPLETE)
                done_reg[e_idx] <= 1'b1;
            if (q_item.command == CMD_EXCEPT)
                fault_reg[e_idx] <= 1'b1;
            if (q_item.command == CMD_CKPT && slot_ok)
                saved_reg[slot_i] <= tail_reg;
        end
    end
endmodule
`default_nettype wire

// File: sv/active_list_reorder_buffer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// active_list_reorder_buffer_core
// Circular active list with per-entry free physical register.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive the item fields and raise start; the item is
//   taken at an edge with start high and busy low. busy is high while the
//   two-entry command queue is full.
//   Result channel: strobe marks one result for one cycle; last flags the
//   final result of an item. The receiver cannot stall.
//   A command taken into an empty queue gives its first result in the next
//   cycle. Every command gives one result, except retire, which gives one
//   result per freed entry (1 to RETIRE_MAX results), one after another on
//   the single result port.
//   Reset empties the list, resets the pointers and restores each entry's
//   free register to LOGICAL_REGS plus its index.
// ----------------------------------------------------------------------------
module active_list_reorder_buffer_core
#(
    parameter int ENTRIES      = alrob_pkg::DEF_ENTRIES,
    parameter int RETIRE_MAX   = alrob_pkg::DEF_RETIRE_MAX,
    parameter int CHECKPOINTS  = alrob_pkg::DEF_CHECKPOINTS,
    parameter int LOGICAL_REGS = alrob_pkg::DEF_LOGICAL_REGS
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire logic [alrob_pkg::CMD_W-1:0]  command,
    input  wire logic [alrob_pkg::IDX_W-1:0]  entry_index,
    input  wire logic [alrob_pkg::SLOT_W-1:0] slot,
    input  wire logic [alrob_pkg::PC_W-1:0]   pc_tag,
    input  wire logic [alrob_pkg::DST_W-1:0]  dest_reg,
    input  wire logic [alrob_pkg::TAG_W-1:0]  old_tag,
    output logic      strobe,
    output logic [alrob_pkg::ST_W-1:0]  status,
    output logic [alrob_pkg::TAG_W-1:0] new_tag,
    output logic [alrob_pkg::IDX_W-1:0] entry_tag,
    output logic [alrob_pkg::TAG_W-1:0] freed_tag,
    output logic [alrob_pkg::DST_W-1:0] dest_reg_out,
    output logic [alrob_pkg::PC_W-1:0]  pc_out,
    output logic      head_exception,
    output logic [alrob_pkg::OCC_W-1:0] occupancy,
    output logic      last
);
    import alrob_pkg::*;

    item_t in_item, q_item;
    logic  q_valid, pop, push;

    assign in_item = '{command, entry_index, slot, pc_tag, dest_reg, old_tag};
    assign push    = start && !busy;

    alrob_front u_front
    (
        .clk(clk), .rst_n(rst_n), .push(push), .push_item(in_item),
        .full(busy), .q_valid(q_valid), .q_item(q_item), .pop(pop)
    );

    alrob_back
    #(
        .ENTRIES(ENTRIES), .RETIRE_MAX(RETIRE_MAX),
        .CHECKPOINTS(CHECKPOINTS), .LOGICAL_REGS(LOGICAL_REGS)
    ) u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_item(q_item),
        .pop(pop), .strobe(strobe), .status(status), .new_tag(new_tag),
        .entry_tag(entry_tag), .freed_tag(freed_tag),
        .dest_reg_out(dest_reg_out), .pc_out(pc_out),
        .head_exception(head_exception), .occupancy(occupancy), .last(last)
    );

    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == ST_EMPTY |-> last)
        else $error("empty status not final");
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        last |-> strobe)
        else $error("last without strobe");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && status == ST_FULL |-> last && new_tag == '0)
        else $error("refused accept carries data");
endmodule
`default_nettype wire

// File: tb/sv/active_list_reorder_buffer_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// active_list_reorder_buffer_core_test
// Self-checking bench for the active list: a directed table of commands,
// then random command streams with sender gaps, each result compared with
// the table or a cycle-free model of the list kept inside the bench.
// ----------------------------------------------------------------------------
module active_list_reorder_buffer_core_test;
    import alrob_pkg::*;

    localparam int NUM_ENTRIES = DEF_ENTRIES;
    localparam int NUM_SLOTS   = DEF_CHECKPOINTS;
    localparam int RETIRE_W    = DEF_RETIRE_MAX;
    localparam int FREE_BASE   = DEF_LOGICAL_REGS;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 480;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN_HI = 4'd15;

    typedef struct packed {
        logic [ST_W-1:0]  st;
        logic [TAG_W-1:0] nt;
        logic [IDX_W-1:0] et;
        logic [TAG_W-1:0] ftg;
        logic [DST_W-1:0] dr;
        logic [PC_W-1:0]  pc;
        logic             hx;
        logic [OCC_W-1:0] occ;
        logic             lst;
    } outcome_t;

    typedef struct {
        logic             dn [NUM_ENTRIES];
        logic             fl [NUM_ENTRIES];
        logic [PC_W-1:0]  pc [NUM_ENTRIES];
        logic [DST_W-1:0] ds [NUM_ENTRIES];
        logic [TAG_W-1:0] ot [NUM_ENTRIES];
        logic [TAG_W-1:0] fr [NUM_ENTRIES];
        logic [OCC_W-1:0] tail;
        logic [OCC_W-1:0] head;
        logic [OCC_W-1:0] sv [NUM_SLOTS];
        bit               dw [NUM_ENTRIES];
        bit               fw [NUM_ENTRIES];
        bit               pw [NUM_ENTRIES];
        bit               sw [NUM_SLOTS];
    } list_state_t;

    typedef struct {
        item_t    it;
        bit       known;
        outcome_t r;
    } row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  entry_index;
    logic [SLOT_W-1:0] slot;
    logic [PC_W-1:0]   pc_tag;
    logic [DST_W-1:0]  dest_reg;
    logic [TAG_W-1:0]  old_tag;
    logic strobe;
    logic [ST_W-1:0]  status;
    logic [TAG_W-1:0] new_tag;
    logic [IDX_W-1:0] entry_tag;
    logic [TAG_W-1:0] freed_tag;
    logic [DST_W-1:0] dest_reg_out;
    logic [PC_W-1:0]  pc_out;
    logic head_exception;
    logic [OCC_W-1:0] occupancy;
    logic last;

    list_state_t list_now;
    outcome_t    pending_results[$];
    row_t        directed_rows[$];
    int          mismatches;
    int          cycles;

    active_list_reorder_buffer_core u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .command        (command),
        .entry_index    (entry_index),
        .slot           (slot),
        .pc_tag         (pc_tag),
        .dest_reg       (dest_reg),
        .old_tag        (old_tag),
        .strobe         (strobe),
        .status         (status),
        .new_tag        (new_tag),
        .entry_tag      (entry_tag),
        .freed_tag      (freed_tag),
        .dest_reg_out   (dest_reg_out),
        .pc_out         (pc_out),
        .head_exception (head_exception),
        .occupancy      (occupancy),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic bit head_faulting(input list_state_t s, inout bit bad);
        logic [IDX_W-1:0] h;
        h = s.head[IDX_W-1:0];
        if (s.head == s.tail)
            return 1'b0;
        if (!(s.dw[h] && s.fw[h]))
            bad = 1'b1;
        return s.dn[h] && s.fl[h];
    endfunction

    function automatic void reset_list(output list_state_t s);
        for (int i = 0; i < NUM_ENTRIES; i++)
        begin
            s.dn[i] = 1'b0;
            s.fl[i] = 1'b0;
            s.pc[i] = '0;
            s.ds[i] = '0;
            s.ot[i] = '0;
            s.fr[i] = TAG_W'(FREE_BASE + i);
            s.dw[i] = 1'b0;
            s.fw[i] = 1'b0;
            s.pw[i] = 1'b0;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            s.sv[i] = '0;
            s.sw[i] = 1'b0;
        end
        s.tail = '0;
        s.head = '0;
    endfunction

    // Returns 1 if the item would read an entry or slot never written.
    function automatic bit step_list(inout list_state_t s, input item_t it,
                                     output outcome_t res[$]);
        outcome_t r;
        bit bad;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] h;
        logic [IDX_W-1:0] t;
        logic [OCC_W-1:0] occ;
        bad = 1'b0;
        res.delete();
        r = '0;
        idx = it.entry_index;
        occ = s.tail - s.head;
        case (cmd_t'(it.command))
            CMD_ACCEPT:
            begin
                if (occ >= OCC_W'(NUM_ENTRIES))
                    r.st = ST_FULL;
                else
                begin
                    t = s.tail[IDX_W-1:0];
                    s.dn[t] = 1'b0;
                    s.fl[t] = 1'b0;
                    s.pc[t] = it.pc_tag;
                    s.ds[t] = it.dest_reg;
                    s.ot[t] = it.old_tag;
                    s.dw[t] = 1'b1;
                    s.fw[t] = 1'b1;
                    s.pw[t] = 1'b1;
                    r.nt = s.fr[t];
                    r.et = t;
                    s.tail = s.tail + 1'b1;
                end
                res.push_back(r);
            end
            CMD_COMPLETE:
            begin
                s.dn[idx] = 1'b1;
                s.dw[idx] = 1'b1;
                res.push_back(r);
            end
            CMD_EXCEPT:
            begin
                s.fl[idx] = 1'b1;
                s.fw[idx] = 1'b1;
                res.push_back(r);
            end
            CMD_RETIRE:
            begin
                while (res.size() < RETIRE_W && s.head != s.tail)
                begin
                    h = s.head[IDX_W-1:0];
                    if (!(s.dw[h] && s.fw[h]))
                        bad = 1'b1;
                    if (!s.dn[h] || s.fl[h])
                        break;
                    if (!s.pw[h])
                        bad = 1'b1;
                    s.fr[h] = s.ot[h];
                    r = '0;
                    r.ftg = s.ot[h];
                    res.push_back(r);
                    s.head = s.head + 1'b1;
                end
                if (res.size() == 0)
                begin
                    r = '0;
                    r.st = ST_EMPTY;
                    res.push_back(r);
                end
            end
            CMD_CKPT:
            begin
                s.sv[it.slot] = s.tail;
                s.sw[it.slot] = 1'b1;
                res.push_back(r);
            end
            CMD_REWIND:
            begin
                if (!s.sw[it.slot])
                    bad = 1'b1;
                s.tail = s.sv[it.slot];
                res.push_back(r);
            end
            CMD_UNMAP:
            begin
                if (occ == 0)
                    r.st = ST_EMPTY;
                else
                begin
                    s.tail = s.tail - 1'b1;
                    t = s.tail[IDX_W-1:0];
                    if (!s.pw[t])
                        bad = 1'b1;
                    r.ftg = s.ot[t];
                    r.dr = s.ds[t];
                end
                res.push_back(r);
            end
            CMD_READ_PC:
            begin
                if (!s.pw[idx])
                    bad = 1'b1;
                r.pc = s.pc[idx];
                res.push_back(r);
            end
            CMD_HEAD_Q:
            begin
                h = s.head[IDX_W-1:0];
                if (head_faulting(s, bad))
                begin
                    if (!s.pw[h])
                        bad = 1'b1;
                    r.pc = s.pc[h];
                end
                res.push_back(r);
            end
            default:
                res.push_back(r);
        endcase
        for (int k = 0; k < res.size(); k++)
        begin
            res[k].hx = head_faulting(s, bad);
            res[k].occ = s.tail - s.head;
            res[k].lst = (k == res.size() - 1);
        end
        return bad;
    endfunction

    function automatic item_t random_item(input list_state_t s);
        item_t it;
        int pick;
        logic [OCC_W-1:0] occ;
        occ = s.tail - s.head;
        it.entry_index = IDX_W'($urandom);
        it.slot = SLOT_W'($urandom);
        it.pc_tag = $urandom;
        it.dest_reg = DST_W'($urandom);
        it.old_tag = TAG_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 34)
            it.command = CMD_ACCEPT;
        else if (pick < 60)
        begin
            it.command = CMD_COMPLETE;
            if (occ != 0 && occ <= OCC_W'(NUM_ENTRIES))
                it.entry_index = IDX_W'(s.head + $urandom_range(occ - 1));
        end
        else if (pick < 63)
            it.command = CMD_EXCEPT;
        else if (pick < 78)
            it.command = CMD_RETIRE;
        else if (pick < 83)
            it.command = CMD_CKPT;
        else if (pick < 87)
            it.command = CMD_REWIND;
        else if (pick < 92)
            it.command = CMD_UNMAP;
        else if (pick < 95)
            it.command = CMD_READ_PC;
        else if (pick < 98)
            it.command = CMD_HEAD_Q;
        else
            it.command = CMD_W'($urandom_range(CMD_UNKNOWN_LO, CMD_UNKNOWN_HI));
        return it;
    endfunction

    function automatic item_t safe_item(input list_state_t s);
        item_t it;
        list_state_t trial;
        outcome_t scratch[$];
        for (int tries = 0; tries < 64; tries++)
        begin
            it = random_item(s);
            trial = s;
            if (!step_list(trial, it, scratch))
                return it;
        end
        it = '0;
        it.command = CMD_UNKNOWN_HI;
        return it;
    endfunction

    function automatic item_t mk_item(input logic [CMD_W-1:0] c, input int idx,
                                      input int sl, input logic [PC_W-1:0] pc,
                                      input int dst, input int ot);
        item_t it;
        it.command = c;
        it.entry_index = IDX_W'(idx);
        it.slot = SLOT_W'(sl);
        it.pc_tag = pc;
        it.dest_reg = DST_W'(dst);
        it.old_tag = TAG_W'(ot);
        return it;
    endfunction

    function automatic outcome_t mk_out(input logic [ST_W-1:0] st, input int nt,
                                        input int et, input int ftg, input int dr,
                                        input logic [PC_W-1:0] pc, input bit hx,
                                        input int occ);
        outcome_t r;
        r.st = st;
        r.nt = TAG_W'(nt);
        r.et = IDX_W'(et);
        r.ftg = TAG_W'(ftg);
        r.dr = DST_W'(dr);
        r.pc = pc;
        r.hx = hx;
        r.occ = OCC_W'(occ);
        r.lst = 1'b1;
        return r;
    endfunction

    function automatic void add_row(input item_t it, input bit known, input outcome_t r);
        row_t row;
        row.it = it;
        row.known = known;
        row.r = r;
        directed_rows.push_back(row);
    endfunction

    task automatic send_item(input item_t it);
        command     <= it.command;
        entry_index <= it.entry_index;
        slot        <= it.slot;
        pc_tag      <= it.pc_tag;
        dest_reg    <= it.dest_reg;
        old_tag     <= it.old_tag;
        start       <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic maybe_idle(input int idle_pct);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain_results;
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        outcome_t got;
        outcome_t want;
        if (rst_n && strobe)
        begin
            got = '{status, new_tag, entry_tag, freed_tag, dest_reg_out, pc_out,
                    head_exception, occupancy, last};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL active_list_reorder_buffer_core");
            $finish;
        end
    end

    initial
    begin
        outcome_t got_list[$];
        item_t it;
        int phase_pct[3];
        phase_pct = '{16, 80, 0};
        mismatches = 0;
        cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        command = '0;
        entry_index = '0;
        slot = '0;
        pc_tag = '0;
        dest_reg = '0;
        old_tag = '0;
        reset_list(list_now);

        add_row(mk_item(CMD_HEAD_Q, 0, 0, 0, 0, 0), 1, mk_out(ST_DONE, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(CMD_UNMAP, 0, 0, 0, 0, 0), 1, mk_out(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(CMD_RETIRE, 0, 0, 0, 0, 0), 1, mk_out(ST_EMPTY, 0, 0, 0, 0, 0, 0, 0));
        add_row(mk_item(CMD_ACCEPT, 31, 3, 32'hFFFF_FFFF, 31, 63), 1,
                mk_out(ST_DONE, 32, 0, 0, 0, 0, 0, 1));
        add_row(mk_item(CMD_ACCEPT, 0, 0, 0, 0, 0), 1, mk_out(ST_DONE, 33, 1, 0, 0, 0, 0, 2));
        add_row(mk_item(CMD_CKPT, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_ACCEPT, 0, 0, 32'h1234_5678, 5, 7), 1,
                mk_out(ST_DONE, 34, 2, 0, 0, 0, 0, 3));
        add_row(mk_item(CMD_READ_PC, 0, 0, 0, 0, 0), 1,
                mk_out(ST_DONE, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 3));
        add_row(mk_item(CMD_EXCEPT, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_COMPLETE, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_HEAD_Q, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_RETIRE, 0, 0, 0, 0, 0), 1, mk_out(ST_EMPTY, 0, 0, 0, 0, 0, 1, 3));
        add_row(mk_item(CMD_REWIND, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_UNMAP, 0, 0, 0, 0, 0), 1, mk_out(ST_DONE, 0, 0, 0, 0, 0, 1, 1));
        add_row(mk_item(CMD_ACCEPT, 0, 0, 32'h8000_0001, 9, 40), 0, '0);
        add_row(mk_item(CMD_CKPT, 0, 3, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_COMPLETE, 31, 0, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_UNMAP, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_UNMAP, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_REWIND, 0, 3, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_UNKNOWN_HI, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_UNMAP, 0, 0, 0, 0, 0), 0, '0);
        add_row(mk_item(CMD_UNMAP, 0, 0, 0, 0, 0), 0, '0);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].it);
            void'(step_list(list_now, directed_rows[i].it, got_list));
            if (directed_rows[i].known)
                pending_results.push_back(directed_rows[i].r);
            else
                foreach (got_list[k])
                    pending_results.push_back(got_list[k]);
            maybe_idle(phase_pct[0]);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                it = safe_item(list_now);
                send_item(it);
                void'(step_list(list_now, it, got_list));
                foreach (got_list[k])
                    pending_results.push_back(got_list[k]);
                maybe_idle(phase_pct[ph]);
            end
            drain_results();
        end

        repeat (4 * RETIRE_W + 8) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS active_list_reorder_buffer_core");
        else
            $display("FAIL active_list_reorder_buffer_core");
        $finish;
    end

endmodule

// File: active_list_reorder_buffer_core.f
sv/alrob_pkg.sv
sv/alrob_front.sv
sv/alrob_back.sv
sv/active_list_reorder_buffer_core.sv
tb/sv/active_list_reorder_buffer_core_test.sv
